>>> src/stereo_pan_law_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo pan law block
// Each macro expands to one labeled concurrent assertion. The assertion is
// clocked on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_PAN_LAW_MACROS_SVH
`define STEREO_PAN_LAW_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define SPL_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check that post holds in the cycle after pre.
`define SPL_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/spl_pkg.sv
// ----------------------------------------------------------------------------
// spl_pkg
// Shared widths, codes, gain tables and per-side request types for the
// stereo pan law block.
// ----------------------------------------------------------------------------
package spl_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int PAN_BITS    = 16;
    localparam int TAB_BITS    = 8;
    localparam int TAB_N       = 1 << TAB_BITS;
    localparam int GAIN_BITS   = 17;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
    localparam int ROUND_BITS  = SAMPLE_BITS + 2;
    localparam int PEXT_BITS   = PAN_BITS + 1;

    // register indexes
    localparam logic [0:0] CFG_PAN_BASE = 1'd0;
    localparam logic [0:0] CFG_PAN_LAW  = 1'd1;

    // pan laws
    localparam logic [1:0] MODE_LINEAR   = 2'd0;
    localparam logic [1:0] MODE_POWER    = 2'd1;
    localparam logic [1:0] MODE_SQRT     = 2'd2;
    localparam logic [1:0] MODE_ADVANCED = 2'd3;

    localparam logic [GAIN_BITS-1:0]  Q15_ONE   = GAIN_BITS'(32768);
    localparam logic [TAB_BITS:0]     IDX_FULL  = (TAB_BITS+1)'(TAB_N);
    localparam logic [TAB_BITS+1:0]   PHASE_OFS = (TAB_BITS+2)'(TAB_N / 2);
    localparam logic [PEXT_BITS-1:0]  I_BIAS    = PEXT_BITS'(1 << (15 - TAB_BITS));
    localparam logic [PEXT_BITS-1:0]  J_BIAS    = PEXT_BITS'(1 << (14 - TAB_BITS));
    localparam logic [PROD_BITS-1:0]  RND_HALF  = PROD_BITS'(16384);

    localparam logic signed [ROUND_BITS-1:0] RND_HI =
        ROUND_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ROUND_BITS-1:0] RND_LO = ~RND_HI;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    typedef logic [15:0] tab_t [TAB_N];

    typedef struct packed {
        logic [1:0]           mode;
        logic [TAB_BITS:0]    idx;
        logic                 neg;
        logic [GAIN_BITS-1:0] lin;
    } side_req_t;

    typedef struct packed {
        logic gain;
        logic mult;
        logic sat;
    } adv_t;

    // Quarter-wave sine in Q15, Q30 Taylor series with seven correction terms.
    function automatic tab_t build_sine();
        tab_t               t;
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        for (int k = 0; k < TAB_N; k++) begin
            x    = (PI_HALF_Q30 * 64'(k) + 64'(TAB_N / 2)) >> TAB_BITS;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 7; n++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                case (n)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    default: term = term / 64'd210;
                endcase
                if ((n & 1) == 1)
                    sum = sum - $signed(term);
                else
                    sum = sum + $signed(term);
            end
            if (sum < 0)
                sum = 0;
            q = (sum + 64'sd16384) >>> 15;
            if (q > 64'sd32768)
                q = 64'sd32768;
            t[k] = q[15:0];
        end
        return t;
    endfunction

    // Square root table in Q15, bit-by-bit integer root.
    function automatic tab_t build_root();
        tab_t        t;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        for (int k = 0; k < TAB_N; k++) begin
            v = 64'(k) << (32 - TAB_BITS);
            r = 64'd0;
            b = 64'd1 << 62;
            for (int m = 0; m < 32; m++) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            t[k] = 16'((r + 64'd1) >> 1);
        end
        return t;
    endfunction

    localparam tab_t SINE_TAB = build_sine();
    localparam tab_t ROOT_TAB = build_root();

    // Read a table at 0..N; for both tables a read at N returns exactly one.
    function automatic logic [GAIN_BITS-1:0] tab_read(logic use_root,
                                                      logic [TAB_BITS:0] idx);
        logic [15:0] v;
        v = use_root ? ROOT_TAB[idx[TAB_BITS-1:0]] : SINE_TAB[idx[TAB_BITS-1:0]];
        return idx[TAB_BITS] ? Q15_ONE : {1'b0, v};
    endfunction

endpackage

>>> src/spl_side.sv
// ----------------------------------------------------------------------------
// spl_side
// One output channel: gain lookup, gain times sample, round and saturate.
// ----------------------------------------------------------------------------
module spl_side (
    input  logic                                  clk,
    input  spl_pkg::adv_t                         adv,
    input  spl_pkg::side_req_t                    req,
    input  logic signed [spl_pkg::SAMPLE_BITS-1:0] sample,
    output logic signed [spl_pkg::SAMPLE_BITS-1:0] samp_out
);

    logic [spl_pkg::GAIN_BITS-1:0]         mag;
    logic signed [spl_pkg::GAIN_BITS-1:0]  gain_next;
    logic signed [spl_pkg::GAIN_BITS-1:0]  gain_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic signed [spl_pkg::PROD_BITS-1:0]  prod_next;
    logic signed [spl_pkg::PROD_BITS-1:0]  prod_reg;
    logic [spl_pkg::PROD_BITS-1:0]         rnd_sum;
    logic signed [spl_pkg::ROUND_BITS-1:0] rnd;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] out_next;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] out_reg;

    // gain stage
    always_comb
    begin
        if (req.mode == spl_pkg::MODE_LINEAR)
            mag = req.lin;
        else
            mag = spl_pkg::tab_read(req.mode == spl_pkg::MODE_SQRT, req.idx);
        gain_next = req.neg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (adv.gain)
        begin
            gain_reg   <= gain_next;
            sample_reg <= sample;
        end
    end

    // multiply stage
    assign prod_next = gain_reg * sample_reg;

    always_ff @(posedge clk)
    begin
        if (adv.mult)
            prod_reg <= prod_next;
    end

    // round half up, then clip to the sample range
    always_comb
    begin
        rnd_sum = prod_reg + spl_pkg::RND_HALF;
        rnd     = $signed(rnd_sum[spl_pkg::PROD_BITS-1:15]);
        if (rnd > spl_pkg::RND_HI)
            out_next = spl_pkg::RND_HI[spl_pkg::SAMPLE_BITS-1:0];
        else if (rnd < spl_pkg::RND_LO)
            out_next = spl_pkg::RND_LO[spl_pkg::SAMPLE_BITS-1:0];
        else
            out_next = rnd[spl_pkg::SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.sat)
            out_reg <= out_next;
    end

    assign samp_out = out_reg;

endmodule

>>> src/stereo_pan_law.sv
// Throughput: one word per cycle while out_stall is low; five register stages
// (pan sum, table index, gain lookup, multiply, round and saturate) each take
// a new word every cycle unless out_stall holds them.
// A stage empties into the next whenever that one moves, so bubbles close up.
// Reset: rst_n clears all valid bits, pan_base to center and the law to linear.
// ----------------------------------------------------------------------------
// stereo_pan_law
// Mono to stereo panner with four selectable pan laws (linear, equal power,
// square root, advanced), fed by a base pan register plus per-word modulation.
// ----------------------------------------------------------------------------
`include "stereo_pan_law_macros.svh"

module stereo_pan_law (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_we,
    input  logic [0:0]                             cfg_index,
    input  logic [15:0]                            cfg_data,
    // input words
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [spl_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic signed [spl_pkg::PAN_BITS-1:0]    pan_mod,
    // output words
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [spl_pkg::SAMPLE_BITS-1:0] left_out,
    output logic signed [spl_pkg::SAMPLE_BITS-1:0] right_out
);

    localparam int STAGES = 5;

    // ------------------------------------------------------------------
    // Configuration registers; user writes only when pipe is empty, unchecked.
    // ------------------------------------------------------------------
    logic signed [spl_pkg::PAN_BITS-1:0] pan_base_reg;
    logic [1:0]                          pan_law_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_base_reg <= '0;
            pan_law_reg  <= spl_pkg::MODE_LINEAR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spl_pkg::CFG_PAN_BASE: pan_base_reg <= $signed(cfg_data);
                spl_pkg::CFG_PAN_LAW:  pan_law_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control. A stage loads when it is empty or when the stage
    // after it loads; the output register loads when the sink takes it.
    // ------------------------------------------------------------------
    logic [STAGES:1]   vld_reg;
    logic [STAGES:1]   vld_next;
    logic [STAGES+1:1] ld;

    always_comb
    begin
        ld[STAGES+1] = !out_stall;
        for (int k = STAGES; k >= 1; k--)
            ld[k] = !vld_reg[k] || ld[k+1];
        vld_next[1] = ld[1] ? in_valid : vld_reg[1];
        for (int k = 2; k <= STAGES; k++)
            vld_next[k] = ld[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !ld[1];
    assign out_valid = vld_reg[STAGES];

    // ------------------------------------------------------------------
    // Stage 1: add modulation to the base pan, clamp to Q1.15 and shift
    // the result to an unsigned position p16 in 0..65535.
    // ------------------------------------------------------------------
    logic signed [spl_pkg::PAN_BITS:0]      pan_sum;
    logic [spl_pkg::PAN_BITS-1:0]           pan_clamped;
    logic [spl_pkg::PAN_BITS-1:0]           p16_next;
    logic [spl_pkg::PAN_BITS-1:0]           p16_reg;
    logic [1:0]                             mode_s1_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] sample_s1_reg;

    always_comb
    begin
        pan_sum = {pan_base_reg[spl_pkg::PAN_BITS-1], pan_base_reg}
                + {pan_mod[spl_pkg::PAN_BITS-1], pan_mod};
        // overflow shows as the two top bits disagreeing; saturate by sign
        if (pan_sum[spl_pkg::PAN_BITS] != pan_sum[spl_pkg::PAN_BITS-1])
            pan_clamped = pan_sum[spl_pkg::PAN_BITS]
                        ? {1'b1, {(spl_pkg::PAN_BITS-1){1'b0}}}
                        : {1'b0, {(spl_pkg::PAN_BITS-1){1'b1}}};
        else
            pan_clamped = pan_sum[spl_pkg::PAN_BITS-1:0];
        // adding one half of full scale flips the sign bit
        p16_next = pan_clamped ^ {1'b1, {(spl_pkg::PAN_BITS-1){1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            p16_reg       <= p16_next;
            mode_s1_reg   <= pan_law_reg;
            sample_s1_reg <= sample_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: table indexes per side. Equal power and square root use
    // index i in 0..N; the advanced law works on phase j in 0..2N and
    // folds it into a quarter wave with a sign.
    // ------------------------------------------------------------------
    function automatic spl_pkg::side_req_t fold(logic [spl_pkg::TAB_BITS+1:0] u,
                                                logic [1:0] mode,
                                                logic [spl_pkg::GAIN_BITS-1:0] lin);
        spl_pkg::side_req_t        req;
        logic [spl_pkg::TAB_BITS:0] r;
        r        = {1'b0, u[spl_pkg::TAB_BITS-1:0]};
        req.mode = mode;
        req.lin  = lin;
        req.neg  = u[spl_pkg::TAB_BITS+1];
        req.idx  = u[spl_pkg::TAB_BITS] ? spl_pkg::IDX_FULL - r : r;
        return req;
    endfunction

    logic [spl_pkg::PEXT_BITS-1:0]  p_ext;
    logic [spl_pkg::PEXT_BITS-1:0]  i_sum;
    logic [spl_pkg::PEXT_BITS-1:0]  j_sum;
    logic [spl_pkg::PEXT_BITS-1:0]  lin_sum;
    logic [spl_pkg::TAB_BITS:0]     idx_i;
    logic [spl_pkg::TAB_BITS+1:0]   phase_j;
    logic [spl_pkg::GAIN_BITS-1:0]  lin_l;
    logic [spl_pkg::GAIN_BITS-1:0]  lin_r;
    spl_pkg::side_req_t             req_l_next;
    spl_pkg::side_req_t             req_r_next;
    spl_pkg::side_req_t             req_l_reg;
    spl_pkg::side_req_t             req_r_reg;
    logic signed [spl_pkg::SAMPLE_BITS-1:0] sample_s2_reg;

    always_comb
    begin
        p_ext   = {1'b0, p16_reg};
        i_sum   = p_ext + spl_pkg::I_BIAS;
        j_sum   = p_ext + spl_pkg::J_BIAS;
        lin_sum = p_ext + spl_pkg::PEXT_BITS'(1);
        idx_i   = i_sum[spl_pkg::PEXT_BITS-1:spl_pkg::PEXT_BITS-1-spl_pkg::TAB_BITS];
        phase_j = j_sum[spl_pkg::PEXT_BITS-1:spl_pkg::PEXT_BITS-2-spl_pkg::TAB_BITS];
        lin_r   = {1'b0, lin_sum[spl_pkg::PEXT_BITS-1:1]};
        lin_l   = spl_pkg::Q15_ONE - lin_r;
        case (mode_s1_reg)
            spl_pkg::MODE_ADVANCED:
            begin
                // left is sin(t), right is sin(t + N), with t = j - N/2
                req_l_next = fold(phase_j - spl_pkg::PHASE_OFS, mode_s1_reg, lin_l);
                req_r_next = fold(phase_j + spl_pkg::PHASE_OFS, mode_s1_reg, lin_r);
            end
            default:
            begin
                req_l_next = '{mode_s1_reg, spl_pkg::IDX_FULL - idx_i, 1'b0, lin_l};
                req_r_next = '{mode_s1_reg, idx_i, 1'b0, lin_r};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            req_l_reg     <= req_l_next;
            req_r_reg     <= req_r_next;
            sample_s2_reg <= sample_s1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 to 5: gain lookup, multiply, round and saturate per side.
    // ------------------------------------------------------------------
    spl_pkg::adv_t adv;

    assign adv.gain = ld[3];
    assign adv.mult = ld[4];
    assign adv.sat  = ld[5];

    spl_side u_left (
        .clk      (clk),
        .adv      (adv),
        .req      (req_l_reg),
        .sample   (sample_s2_reg),
        .samp_out (left_out)
    );

    spl_side u_right (
        .clk      (clk),
        .adv      (adv),
        .req      (req_r_reg),
        .sample   (sample_s2_reg),
        .samp_out (right_out)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // input may stall only when every stage is full and the sink holds back
    `SPL_ASSERT_NOW(a_stall_only_full, in_stall,
                    out_valid && out_stall && (&vld_reg),
                    "input stalled with room in the pipe")
    // the linear law splits full scale between the two sides
    `SPL_ASSERT_NOW(a_linear_sum,
                    vld_reg[2] && req_l_reg.mode == spl_pkg::MODE_LINEAR,
                    req_l_reg.lin + req_r_reg.lin == spl_pkg::Q15_ONE,
                    "linear gains do not sum to one")
    // table laws read mirrored indexes
    `SPL_ASSERT_NOW(a_mirror_idx,
                    vld_reg[2] && (req_l_reg.mode == spl_pkg::MODE_POWER
                                   || req_l_reg.mode == spl_pkg::MODE_SQRT),
                    (spl_pkg::TAB_BITS+2)'(req_l_reg.idx)
                    + (spl_pkg::TAB_BITS+2)'(req_r_reg.idx)
                    == (spl_pkg::TAB_BITS+2)'(spl_pkg::TAB_N),
                    "left and right indexes not mirrored")
    // an output word leaves only when the sink takes it
    `SPL_ASSERT_NEXT(a_no_drop, out_valid && out_stall, out_valid,
                     "output word dropped under stall")

endmodule
